[rtl/cpjm_pkg.sv]
package cpjm_pkg;

  localparam int unsigned TS_W       = 64;
  localparam int unsigned US_W       = 32;
  localparam int unsigned CFG_IDX_W  = 2;

  // Deltas at or above 1000 * 2^32 ns saturate the period, so only the low
  // 42 bits of the delta take part in the division. Dividing by 1000 is a
  // shift by three followed by a reciprocal multiplication for 125, which is
  // exact for every 39-bit dividend.
  localparam int unsigned DELTA_W     = 42;
  localparam int unsigned Q8_W        = DELTA_W - 3;
  localparam int unsigned HALF_W      = 20;
  localparam int unsigned PP_W        = 2 * HALF_W;
  localparam int unsigned SUM_W       = 2 * PP_W;
  localparam int unsigned RECIP_SHIFT = 46;

  // Smallest integer not below 2^46 / 125.
  localparam logic [PP_W-1:0]   RECIP_125 = 40'h83_126E_978E;
  localparam logic [HALF_W-1:0] RECIP_HI  = RECIP_125[PP_W-1:HALF_W];
  localparam logic [HALF_W-1:0] RECIP_LO  = RECIP_125[HALF_W-1:0];

  localparam logic [TS_W-1:0]  SAT_NS     = 64'd4294967296000;

  localparam logic [US_W-1:0]  EXPECTED_RST = 32'd1000;
  localparam logic [US_W-1:0]  WARN_RST     = 32'd50;
  localparam logic [US_W-1:0]  CRIT_RST     = 32'd200;

  localparam int unsigned IN_TDATA_W  = TS_W;
  localparam int unsigned OUT_TDATA_W = 232;

  // Field offsets inside the result tdata.
  localparam int unsigned OFS_JIT     = 0;
  localparam int unsigned OFS_WARN    = 32;
  localparam int unsigned OFS_CRIT    = 33;
  localparam int unsigned OFS_CYC     = 34;
  localparam int unsigned OFS_MAX     = 66;
  localparam int unsigned OFS_AVG     = 98;
  localparam int unsigned OFS_WRN_CNT = 130;
  localparam int unsigned OFS_CRT_CNT = 162;
  localparam int unsigned OFS_PER     = 194;
  localparam int unsigned OFS_OK      = 226;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_EXPECTED = 2'd0,
    REG_WARN     = 2'd1,
    REG_CRIT     = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic            func;
    logic            meas;
    logic            sat;
    logic [Q8_W-1:0] q8;
  } in_stage_t;

  typedef struct packed {
    logic            func;
    logic            meas;
    logic            sat;
    logic [PP_W-1:0] pp_hh;
    logic [PP_W-1:0] pp_hl;
    logic [PP_W-1:0] pp_lh;
    logic [PP_W-1:0] pp_ll;
  } mul_stage_t;

  typedef struct packed {
    logic            func;
    logic            meas;
    logic [US_W-1:0] period;
  } per_stage_t;

  typedef struct packed {
    logic            func;
    logic            meas;
    logic [US_W-1:0] period;
    logic [US_W-1:0] jitter;
  } jit_stage_t;

endpackage

[rtl/cycle_period_jitter_monitor_core.sv]
// Cycle period jitter monitor.
// Input stream: s_axis_tuser selects the operation (0 records the timestamp
// in s_axis_tdata, 1 clears all statistics). Every input transfer produces
// exactly one result transfer on the m_axis side, in order. The result
// carries this item's jitter fields and the statistics after the item;
// m_axis_tuser says whether a jitter was measured.
// Configuration: cfg_valid_i writes cfg_data_i into the register selected by
// cfg_index_i (0 expected period, 1 warning threshold, 2 critical threshold);
// cfg_ready_o is always high and other indexes are ignored. Write only while
// the block is empty.
// A new item is taken every cycle unless a stalled receiver has backed up
// the pipeline. The stages are the input register, the products of a
// reciprocal multiplication for the divide by 1000, the period, the jitter,
// and the statistics update that also holds the result.
// When the receiver stalls, the result register holds, bubbles in the
// pipeline still fill, and s_axis_tready drops once all five stages are full.
// Reset empties the pipeline, restores the statistics to their clear values
// and loads the configuration registers with their defaults.
module cycle_period_jitter_monitor_core
  import cpjm_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // timestamp_ns
  input  logic                   s_axis_tuser,  // func
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // jitter_now_us, warn_now, crit_now, cycles_seen, peak_jitter_us,
  // mean_jitter_us, warnings_seen, criticals_seen, period_us, timing_ok
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                   m_axis_tuser,  // jitter_valid
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [US_W-1:0]        cfg_data_i
);

  function automatic logic [US_W-1:0] sat_inc(input logic [US_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  // Configuration registers.
  logic [US_W-1:0] expected_q, warn_thr_q, crit_thr_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_q <= EXPECTED_RST;
      warn_thr_q <= WARN_RST;
      crit_thr_q <= CRIT_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_EXPECTED: expected_q <= cfg_data_i;
        REG_WARN:     warn_thr_q <= cfg_data_i;
        REG_CRIT:     crit_thr_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Previous timestamp, tracked in transfer order at the input.
  logic            have_prev_q;
  logic [TS_W-1:0] prev_ns_q;
  logic            s_fire;
  logic [TS_W-1:0] delta;
  in_stage_t       a_d;

  assign s_fire = s_axis_tvalid & s_axis_tready;

  always_comb begin
    delta = (s_axis_tdata >= prev_ns_q) ? s_axis_tdata - prev_ns_q : '0;
    a_d.func = s_axis_tuser;
    a_d.meas = have_prev_q & ~s_axis_tuser;
    a_d.sat  = (delta >= SAT_NS);
    a_d.q8   = delta[DELTA_W-1:3];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_prev_q <= 1'b0;
    end else if (s_fire) begin
      have_prev_q <= ~s_axis_tuser;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire && !s_axis_tuser) begin
      prev_ns_q <= s_axis_tdata;
    end
  end

  // Pipeline: input register, partial products, period, jitter, result.
  logic             a_vld_q, a_rdy, b_vld_q, b_rdy, c_vld_q, c_rdy, j_vld_q, j_rdy;
  in_stage_t        a_q;
  mul_stage_t       b_q, b_d;
  per_stage_t       c_q, c_d;
  jit_stage_t       j_q, j_d;
  logic             out_vld_q, out_free, out_move;
  logic [SUM_W-1:0] prod_sum;

  assign out_free = ~out_vld_q | m_axis_tready;
  assign out_move = j_vld_q & out_free;
  assign j_rdy    = ~j_vld_q | out_free;
  assign c_rdy    = ~c_vld_q | j_rdy;
  assign b_rdy    = ~b_vld_q | c_rdy;
  assign a_rdy    = ~a_vld_q | b_rdy;

  assign s_axis_tready = a_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
      j_vld_q <= 1'b0;
    end else begin
      if (a_rdy) begin
        a_vld_q <= s_axis_tvalid;
      end
      if (b_rdy) begin
        b_vld_q <= a_vld_q;
      end
      if (c_rdy) begin
        c_vld_q <= b_vld_q;
      end
      if (j_rdy) begin
        j_vld_q <= c_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      a_q <= a_d;
    end
    if (b_rdy && a_vld_q) begin
      b_q <= b_d;
    end
    if (c_rdy && b_vld_q) begin
      c_q <= c_d;
    end
    if (j_rdy && c_vld_q) begin
      j_q <= j_d;
    end
  end

  // The delta over eight is split in halves and multiplied by both halves
  // of the reciprocal.
  always_comb begin
    b_d.func  = a_q.func;
    b_d.meas  = a_q.meas;
    b_d.sat   = a_q.sat;
    b_d.pp_hh = PP_W'(a_q.q8[Q8_W-1:HALF_W]) * PP_W'(RECIP_HI);
    b_d.pp_hl = PP_W'(a_q.q8[Q8_W-1:HALF_W]) * PP_W'(RECIP_LO);
    b_d.pp_lh = PP_W'(a_q.q8[HALF_W-1:0]) * PP_W'(RECIP_HI);
    b_d.pp_ll = PP_W'(a_q.q8[HALF_W-1:0]) * PP_W'(RECIP_LO);
  end

  // The quotient starts at bit RECIP_SHIFT of the full product.
  always_comb begin
    prod_sum = {b_q.pp_hh, {PP_W{1'b0}}}
             + {{HALF_W{1'b0}}, b_q.pp_hl, {HALF_W{1'b0}}}
             + {{HALF_W{1'b0}}, b_q.pp_lh, {HALF_W{1'b0}}}
             + {{PP_W{1'b0}}, b_q.pp_ll};
    c_d.func   = b_q.func;
    c_d.meas   = b_q.meas;
    c_d.period = b_q.sat ? '1 : prod_sum[RECIP_SHIFT +: US_W];
  end

  // Jitter.
  always_comb begin
    j_d.func   = c_q.func;
    j_d.meas   = c_q.meas;
    j_d.period = c_q.period;
    j_d.jitter = (c_q.period >= expected_q) ? c_q.period - expected_q
                                            : expected_q - c_q.period;
  end

  // Statistics and result register.
  logic [US_W-1:0] cyc_q, peak_q, avg_q, wrn_cnt_q, crt_cnt_q, per_q;
  logic [US_W-1:0] cyc_d, peak_d, avg_d, wrn_cnt_d, crt_cnt_d, per_d;
  logic            ok_q, ok_d;
  logic            jv_q, jv_d, warn_q, warn_d, crit_q, crit_d;
  logic [US_W-1:0] jit_q, jit_d;
  logic [US_W+3:0] avg_sum;

  always_comb begin
    avg_sum = {1'b0, avg_q, 3'b000} - {4'b0000, avg_q} + {4'b0000, j_q.jitter};
    cyc_d     = cyc_q;
    peak_d    = peak_q;
    avg_d     = avg_q;
    wrn_cnt_d = wrn_cnt_q;
    crt_cnt_d = crt_cnt_q;
    per_d     = per_q;
    ok_d      = ok_q;
    jv_d      = 1'b0;
    jit_d     = '0;
    warn_d    = 1'b0;
    crit_d    = 1'b0;
    if (j_q.func) begin
      cyc_d     = '0;
      peak_d    = '0;
      avg_d     = '0;
      wrn_cnt_d = '0;
      crt_cnt_d = '0;
      per_d     = '0;
      ok_d      = 1'b1;
    end else begin
      cyc_d = sat_inc(cyc_q);
      if (j_q.meas) begin
        jv_d   = 1'b1;
        jit_d  = j_q.jitter;
        per_d  = j_q.period;
        avg_d  = avg_sum[US_W+2:3];
        if (j_q.jitter > peak_q) begin
          peak_d = j_q.jitter;
        end
        if (j_q.jitter > warn_thr_q) begin
          warn_d    = 1'b1;
          wrn_cnt_d = sat_inc(wrn_cnt_q);
        end
        if (j_q.jitter > crit_thr_q) begin
          crit_d    = 1'b1;
          crt_cnt_d = sat_inc(crt_cnt_q);
          ok_d      = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      cyc_q     <= '0;
      peak_q    <= '0;
      avg_q     <= '0;
      wrn_cnt_q <= '0;
      crt_cnt_q <= '0;
      per_q     <= '0;
      ok_q      <= 1'b1;
    end else begin
      if (out_free) begin
        out_vld_q <= j_vld_q;
      end
      if (out_move) begin
        cyc_q     <= cyc_d;
        peak_q    <= peak_d;
        avg_q     <= avg_d;
        wrn_cnt_q <= wrn_cnt_d;
        crt_cnt_q <= crt_cnt_d;
        per_q     <= per_d;
        ok_q      <= ok_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_move) begin
      jv_q   <= jv_d;
      jit_q  <= jit_d;
      warn_q <= warn_d;
      crit_q <= crit_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = jv_q;
  assign m_axis_tdata  = {5'b00000, ok_q, per_q, crt_cnt_q, wrn_cnt_q, avg_q, peak_q,
                          cyc_q, crit_q, warn_q, jit_q};

endmodule

[rtl/cpjm_checker.sv]
module cpjm_checker
  import cpjm_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                   m_axis_tuser
);

  // A stalled result must not change.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // With the result register empty, nothing can back up to the input.
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  a_crit_clears_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[OFS_CRIT] |-> !m_axis_tdata[OFS_OK])
    else $error("critical event left timing ok set");

  a_peak_covers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |->
      m_axis_tdata[OFS_MAX +: US_W] >= m_axis_tdata[OFS_JIT +: US_W])
    else $error("peak jitter below current jitter");

endmodule

bind cycle_period_jitter_monitor_core cpjm_checker u_cpjm_checker (.*);
